### rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared definitions for the multi-stack shared-pool unit
// Sizes, operation and status codes, and the word types that pass
// between the front end and the execution back end.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int NUM_STACKS = 128;
  localparam int POOL_NODES = 1024;
  localparam int KEY_WIDTH  = 32;

  localparam int IDX_W    = 7;
  localparam int STACK_AW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int NODE_AW  = $clog2(POOL_NODES);
  localparam int FRESH_W  = NODE_AW + 1;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Classified word as it sits in the queue between front and back.
  typedef struct packed {
    func_t                       func;
    logic                        idx_ok;
    logic [IDX_W-1:0]            stack_index;
    logic signed [KEY_WIDTH-1:0] push_key;
  } item_t;

  // Link field of a node: the node below, or the next free node.
  typedef struct packed {
    logic               valid;
    logic [NODE_AW-1:0] next;
  } link_t;

endpackage

### rtl/core/msp_if.sv
// ----------------------------------------------------------------------------
// msp_in_if / msp_out_if: valid-ready channels of the unit
// One request word in, one result word out.
// ----------------------------------------------------------------------------
interface msp_in_if import msp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [IDX_W-1:0]            stack_index;
  logic signed [KEY_WIDTH-1:0] push_key;

  modport source (output valid, output func, output stack_index, output push_key,
                  input ready);
  modport sink   (input valid, input func, input stack_index, input push_key,
                  output ready);
endinterface

interface msp_out_if import msp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] popped_key;
  logic [1:0]                  status;

  modport source (output valid, output popped_key, output status, input ready);
  modport sink   (input valid, input popped_key, input status, output ready);
endinterface

### rtl/core/multi_stack_shared_pool_unit.sv
// A push word goes from the queue to S_EXEC, where it is written to the result register;
// a pop word passes S_NODE first, and S_EXEC waits while the result register is held.
// The back end takes a new word only once the last has left S_EXEC; for a pop the stack-top
// memory read is followed by the node memory read, and both end in the write-back.
// Reset (synchronous, active high) empties every stack and the free list at once;
// node memory contents are left undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_unit: many LIFO stacks over one node pool
// Push and pop requests are queued by the front end and executed by the
// back end against linked stacks sharing a free list.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_unit import msp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  msp_in_if.sink    item_in,
  msp_out_if.source result_out
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  msp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  msp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .result_out (result_out)
  );

endmodule

### rtl/core/msp_front.sv
// ----------------------------------------------------------------------------
// msp_front: request intake
// Accepts request words, checks the stack index against the stack count
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module msp_front import msp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  msp_in_if.sink    item_in,
  output logic      q_valid,
  output item_t     q_item,
  input  logic      q_ready
);

  item_t       entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push_q;
  logic        pop_q;
  item_t       classified;

  assign item_in.ready = (count != 2'd2);
  assign push_q        = item_in.valid && item_in.ready;
  assign pop_q         = q_valid && q_ready;
  assign q_valid       = (count != 2'd0);
  assign q_item        = entry[rd_ptr];

  always_comb begin
    classified.func        = func_t'(item_in.func);
    classified.idx_ok      = (int'(item_in.stack_index) < NUM_STACKS);
    classified.stack_index = item_in.stack_index;
    classified.push_key    = item_in.push_key;
  end

  always_ff @(posedge clk) begin
    if (push_q) begin
      entry[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_q) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_q) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_q, pop_q})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/msp_back.sv
// ----------------------------------------------------------------------------
// msp_back: stack execution engine
// Holds the stack tops, the node pool and the free list, carries out one
// push or pop at a time and registers the result word.
// ----------------------------------------------------------------------------
module msp_back import msp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  item_t     q_item,
  output logic      q_ready,
  msp_out_if.source result_out
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_NODE = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state;

  // Storage.
  logic [NODE_AW-1:0]          stack_top_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0]       stack_nonempty;
  logic signed [KEY_WIDTH-1:0] node_key  [POOL_NODES];
  link_t                       node_link [POOL_NODES];
  logic [NODE_AW-1:0]          free_head;
  logic                        free_nonempty;
  logic [FRESH_W-1:0]          fresh_count;

  // Current operation and registered read data.
  item_t                       cur;
  logic                        ne_rd;
  logic [NODE_AW-1:0]          top_rd;
  logic signed [KEY_WIDTH-1:0] key_rd;
  link_t                       link_rd;

  // Result register.
  logic                        out_valid;
  logic signed [KEY_WIDTH-1:0] out_key;
  status_t                     out_status;

  logic                        issue;
  logic [STACK_AW-1:0]         q_sidx;
  logic [STACK_AW-1:0]         cur_sidx;
  logic                        node_rd_en;
  logic [NODE_AW-1:0]          node_rd_addr;
  logic                        fire;
  logic                        is_push;
  logic                        pool_full;
  logic                        push_ok;
  logic                        pop_ok;
  logic [NODE_AW-1:0]          take_node;
  logic                        top_we;
  logic [NODE_AW-1:0]          top_wdata;
  logic                        key_we;
  logic                        link_we;
  logic [NODE_AW-1:0]          node_waddr;
  link_t                       link_wdata;

  assign q_ready  = (state == S_IDLE);
  assign issue    = q_valid && q_ready;
  assign q_sidx   = STACK_AW'(q_item.stack_index);
  assign cur_sidx = STACK_AW'(cur.stack_index);

  // A push reads the free-list head node; a pop reads its top node in the
  // cycle after issue, once the top pointer has come out of its memory.
  assign node_rd_en   = issue || (state == S_NODE);
  assign node_rd_addr = (state == S_NODE) ? top_rd : free_head;

  assign fire      = (state == S_EXEC) && (!out_valid || result_out.ready);
  assign is_push   = (cur.func == FUNC_PUSH);
  assign pool_full = !free_nonempty && (fresh_count == FRESH_W'(POOL_NODES));
  assign push_ok   = is_push && cur.idx_ok && !pool_full;
  assign pop_ok    = !is_push && cur.idx_ok && ne_rd;
  assign take_node = free_nonempty ? free_head : fresh_count[NODE_AW-1:0];

  always_comb begin
    top_we           = fire && (push_ok || pop_ok);
    key_we           = fire && push_ok;
    link_we          = fire && (push_ok || pop_ok);
    if (is_push) begin
      top_wdata        = take_node;
      node_waddr       = take_node;
      link_wdata.valid = ne_rd;
      link_wdata.next  = top_rd;
    end else begin
      top_wdata        = link_rd.next;
      node_waddr       = top_rd;
      link_wdata.valid = free_nonempty;
      link_wdata.next  = free_head;
    end
  end

  // Stack top memory.
  always_ff @(posedge clk) begin
    if (issue) begin
      top_rd <= stack_top_mem[q_sidx];
    end
    if (top_we) begin
      stack_top_mem[cur_sidx] <= top_wdata;
    end
  end

  // Node pool memory.
  always_ff @(posedge clk) begin
    if (node_rd_en) begin
      key_rd  <= node_key[node_rd_addr];
      link_rd <= node_link[node_rd_addr];
    end
    if (key_we) begin
      node_key[node_waddr] <= cur.push_key;
    end
    if (link_we) begin
      node_link[node_waddr] <= link_wdata;
    end
  end

  // Operation capture and result payload.
  always_ff @(posedge clk) begin
    if (issue) begin
      cur   <= q_item;
      ne_rd <= stack_nonempty[q_sidx];
    end
    if (fire) begin
      if (pop_ok) begin
        out_key <= key_rd;
      end else begin
        out_key <= '0;
      end
      if (push_ok || pop_ok) begin
        out_status <= ST_DONE;
      end else if (is_push) begin
        out_status <= ST_FULL;
      end else begin
        out_status <= ST_EMPTY;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      stack_nonempty <= '0;
      free_head      <= '0;
      free_nonempty  <= 1'b0;
      fresh_count    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (issue) begin
            state <= (q_item.func == FUNC_POP) ? S_NODE : S_EXEC;
          end
        end
        S_NODE: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (fire) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end

      if (fire && push_ok) begin
        stack_nonempty[cur_sidx] <= 1'b1;
        if (free_nonempty) begin
          free_head     <= link_rd.next;
          free_nonempty <= link_rd.valid;
        end else begin
          fresh_count <= fresh_count + FRESH_W'(1);
        end
      end

      // The popped node goes back on the head of the free list.
      if (fire && pop_ok) begin
        stack_nonempty[cur_sidx] <= link_rd.valid;
        free_head                <= top_rd;
        free_nonempty            <= 1'b1;
      end
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.popped_key = out_key;
  assign result_out.status     = out_status;

endmodule

### dv/multi_stack_shared_pool_unit_tb.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_unit_tb: self-checking bench for the stack unit
// A table of directed push and pop words runs first. Random phases follow
// that mix, fill, saturate and drain the shared node pool. Each result word
// is checked against a typed row's own result or a behavioral copy of the stacks and free list.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_unit_tb;
  import msp_pkg::*;

  typedef struct {
    logic signed [KEY_WIDTH-1:0] popped_key;
    status_t                     status;
  } outcome_t;

  typedef struct {
    func_t                       func;
    logic [IDX_W-1:0]            stack_index;
    logic signed [KEY_WIDTH-1:0] push_key;
    bit                          typed;
    logic signed [KEY_WIDTH-1:0] popped_key;
    status_t                     status;
  } stim_row_t;

  localparam int NUM_DIRECTED = 25;

  // Rows with typed set carry their own expected result; the rest use the
  // shadow stacks.
  stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{FUNC_POP,  7'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{FUNC_POP,  7'd127, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{FUNC_PUSH, 7'd0,   32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
    '{FUNC_PUSH, 7'd0,   32'h8000_0000, 1'b1, 32'h0000_0000, ST_DONE},
    '{FUNC_PUSH, 7'd127, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
    '{FUNC_PUSH, 7'd127, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd0,   32'h0000_0000, 1'b1, 32'h8000_0000, ST_DONE},
    '{FUNC_POP,  7'd0,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_DONE},
    '{FUNC_POP,  7'd0,   32'hDEAD_BEEF, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{FUNC_POP,  7'd127, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd127, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_DONE},
    '{FUNC_POP,  7'd127, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{FUNC_PUSH, 7'd1,   32'h5555_5555, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_PUSH, 7'd2,   32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_PUSH, 7'd1,   32'h1234_5678, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_PUSH, 7'd85,  32'h0F0F_0F0F, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_PUSH, 7'd42,  32'hF0F0_F0F0, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd2,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd1,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_PUSH, 7'd2,   32'h0000_0001, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd85,  32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd42,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd1,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd2,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_DONE},
    '{FUNC_POP,  7'd64,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY}
  };

  logic clk;
  logic rst;

  msp_in_if  item_ch ();
  msp_out_if result_ch ();

  multi_stack_shared_pool_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch)
  );

  // Shadow copy of the stacks, the node pool and the free list.
  logic [NODE_AW-1:0]          top_node [NUM_STACKS];
  bit                          stack_used [NUM_STACKS];
  logic signed [KEY_WIDTH-1:0] pool_key [POOL_NODES];
  link_t                       pool_link [POOL_NODES];
  logic [NODE_AW-1:0]          free_head;
  bit                          free_nonempty;
  logic [FRESH_W-1:0]          fresh_count;

  outcome_t pending_results [$];
  outcome_t oldest_result;
  int       mismatches;
  int       burst_left;
  int       stall_span;
  int       stall_mode;
  logic [7:0] stall_pattern;

  function automatic outcome_t apply_stack_op(func_t op, logic [IDX_W-1:0] idx,
                                              logic signed [KEY_WIDTH-1:0] key);
    outcome_t           res;
    logic [NODE_AW-1:0] n;
    bit                 got;
    res.popped_key = '0;
    res.status     = ST_DONE;
    got            = 1'b0;
    n              = '0;
    if (op == FUNC_PUSH) begin
      if (idx < NUM_STACKS) begin
        // Recycled nodes go out before never-used ones.
        if (free_nonempty) begin
          n             = free_head;
          free_head     = pool_link[n].next;
          free_nonempty = pool_link[n].valid;
          got           = 1'b1;
        end else if (fresh_count < POOL_NODES) begin
          n           = fresh_count[NODE_AW-1:0];
          fresh_count = fresh_count + 1'b1;
          got         = 1'b1;
        end
      end
      if (got) begin
        pool_key[n]       = key;
        pool_link[n]      = '{valid: stack_used[idx], next: top_node[idx]};
        top_node[idx]     = n;
        stack_used[idx]   = 1'b1;
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (idx < NUM_STACKS && stack_used[idx]) begin
        n               = top_node[idx];
        res.popped_key  = pool_key[n];
        top_node[idx]   = pool_link[n].next;
        stack_used[idx] = pool_link[n].valid;
        pool_link[n]    = '{valid: free_nonempty, next: free_head};
        free_head       = n;
        free_nonempty   = 1'b1;
      end else begin
        res.status = ST_EMPTY;
      end
    end
    return res;
  endfunction

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_word(func_t op, logic [IDX_W-1:0] idx,
                           logic signed [KEY_WIDTH-1:0] key, bit typed,
                           outcome_t typed_res);
    outcome_t predicted;
    int       gap;
    item_ch.valid       <= 1'b1;
    item_ch.func        <= op;
    item_ch.stack_index <= idx;
    item_ch.push_key    <= key;
    do @(posedge clk); while (!item_ch.ready);
    predicted = apply_stack_op(op, idx, key);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 7);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic run_phase(int count, int push_pct, int narrow_pct);
    func_t                       op;
    logic [IDX_W-1:0]            idx;
    logic signed [KEY_WIDTH-1:0] key;
    outcome_t                    unused;
    unused = '{popped_key: '0, status: ST_DONE};
    repeat (count) begin
      op = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
      // A narrow index range builds deep stacks; the full range spreads nodes.
      if ($urandom_range(0, 99) < narrow_pct) idx = IDX_W'($urandom_range(0, 3));
      else idx = IDX_W'($urandom_range(0, NUM_STACKS - 1));
      case ($urandom_range(0, 15))
        0:       key = '0;
        1:       key = '1;
        2:       key = {1'b1, {(KEY_WIDTH-1){1'b0}}};
        3:       key = {1'b0, {(KEY_WIDTH-1){1'b1}}};
        default: key = $urandom;
      endcase
      send_word(op, idx, key, 1'b0, unused);
    end
  endtask

  task automatic hold_until_drained();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: spans of always-ready, random stalls, or a fixed stall pattern.
  initial begin
    result_ch.ready = 1'b0;
    stall_span      = 0;
    stall_mode      = 0;
    stall_pattern   = 8'hFF;
    forever begin
      @(negedge clk);
      if (stall_span == 0) begin
        stall_mode    = $urandom_range(0, 2);
        stall_span    = $urandom_range(20, 80);
        stall_pattern = 8'($urandom) | 8'h01;
      end
      stall_span--;
      case (stall_mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
        default: result_ch.ready <= stall_pattern[stall_span % 8];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, popped_key %h status %0d",
                 $time, result_ch.popped_key, result_ch.status);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (result_ch.popped_key !== oldest_result.popped_key) begin
          $display("%0t: popped_key mismatch, expected %h actual %h",
                   $time, oldest_result.popped_key, result_ch.popped_key);
          mismatches++;
        end
        if (result_ch.status !== oldest_result.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, oldest_result.status, result_ch.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    outcome_t typed_res;
    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.func        = FUNC_PUSH;
    item_ch.stack_index = '0;
    item_ch.push_key    = '0;
    mismatches          = 0;
    burst_left          = $urandom_range(1, 8);
    for (int s = 0; s < NUM_STACKS; s++) begin
      top_node[s]   = '0;
      stack_used[s] = 1'b0;
    end
    free_head     = '0;
    free_nonempty = 1'b0;
    fresh_count   = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      typed_res = '{popped_key: directed_rows[r].popped_key,
                    status: directed_rows[r].status};
      send_word(directed_rows[r].func, directed_rows[r].stack_index,
                directed_rows[r].push_key, directed_rows[r].typed, typed_res);
    end

    run_phase(30, 55, 50);
    hold_until_drained();
    // Enough pushes to exhaust the pool, then push on against the full pool.
    run_phase(1035, 100, 30);
    hold_until_drained();
    run_phase(30, 60, 40);
    run_phase(40, 15, 50);
    item_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/msp_pkg.sv
rtl/core/msp_if.sv
rtl/core/msp_front.sv
rtl/core/msp_back.sv
rtl/core/multi_stack_shared_pool_unit.sv
dv/multi_stack_shared_pool_unit_tb.sv
